@@ rtl/sdik_pkg.sv @@
// Shared types and constants for the swerve drive inverse kinematics block.
// Holds the datapath operation codes, the controller/datapath command and
// status structs, fixed-point widths and the CORDIC arctangent table.
package sdik_pkg;

    // Fixed-point widths
    localparam int XW       = 34;   // CORDIC x/y and velocity words
    localparam int ZW       = 26;   // CORDIC angle, 2^-16 degree
    localparam int ITER_W   = 5;    // step counter, covers up to 24 CORDIC steps
    localparam int MW       = 20;   // second multiplier operand
    localparam int PW       = XW + MW;
    localparam int NUM_W    = 42;   // rpm numerator / divider remainder
    localparam int DIV_BITS = 17;   // quotient bits kept before clamping
    localparam int DEN_W    = 19;   // perimeter * 256

    localparam int CORDIC_ITERS_DEF = 16;
    localparam int NUM_WHEELS       = 4;

    // Constants
    localparam logic signed [MW-1:0] INV_GAIN   = 20'sd39797;
    localparam logic signed [MW-1:0] YAW_TERM_C = 20'sd207053;
    localparam logic signed [ZW-1:0] DEG90_Z    = 26'sd5898240;
    localparam logic signed [16:0]   DEG90      = 17'sd5760;
    localparam logic signed [16:0]   DEG180     = 17'sd11520;
    localparam logic signed [16:0]   DEG360     = 17'sd23040;

    // Configuration register indexes
    localparam logic [1:0] REG_RADIUS    = 2'd0;
    localparam logic [1:0] REG_PERIMETER = 2'd1;
    localparam logic [1:0] REG_DIR_MASK  = 2'd2;
    localparam logic [1:0] REG_GEAR      = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PRE,
        OP_ROT,
        OP_GX,
        OP_GY,
        OP_T1,
        OP_T2,
        OP_VLOAD,
        OP_VEC,
        OP_VMAG,
        OP_ANG,
        OP_RMUL,
        OP_RADD,
        OP_DCHK,
        OP_DIV
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              out_load;
        logic [1:0]        wheel;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic pre_more;   // rotation angle still beyond +-90 degrees
    } dp_status_t;

    // arctan(2^-i) in 2^-16 degree
    function automatic logic [21:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [21:0] a;
        unique case (i)
            5'd0:  a = 22'd2949120;
            5'd1:  a = 22'd1740967;
            5'd2:  a = 22'd919879;
            5'd3:  a = 22'd466945;
            5'd4:  a = 22'd234379;
            5'd5:  a = 22'd117304;
            5'd6:  a = 22'd58666;
            5'd7:  a = 22'd29335;
            5'd8:  a = 22'd14668;
            5'd9:  a = 22'd7334;
            5'd10: a = 22'd3667;
            5'd11: a = 22'd1833;
            5'd12: a = 22'd917;
            5'd13: a = 22'd458;
            5'd14: a = 22'd229;
            5'd15: a = 22'd115;
            5'd16: a = 22'd57;
            5'd17: a = 22'd29;
            5'd18: a = 22'd14;
            5'd19: a = 22'd7;
            5'd20: a = 22'd4;
            5'd21: a = 22'd2;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/sdik_dp.sv @@
// Datapath: config registers, shared CORDIC step, shared multiplier,
// restoring divider, per-wheel angle state and the output register.
// Depends on sdik_pkg.
module sdik_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdik_pkg::dp_cmd_t      cmd,
    output sdik_pkg::dp_status_t   status,
    input  logic signed [15:0]     vel_x,
    input  logic signed [15:0]     vel_y,
    input  logic signed [15:0]     rot_rate,
    input  logic signed [14:0]     yaw_angle,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [10:0]            cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             wheel_index,
    output logic signed [15:0]     steer_angle,
    output logic signed [15:0]     motor_rpm,
    output logic                   flipped,
    output logic                   saturated,
    output logic                   last
);
    import sdik_pkg::*;

    // Config registers
    logic [9:0]  radius_reg;
    logic [10:0] perim_reg;
    logic [3:0]  dir_reg;
    logic [5:0]  gear_reg;

    // Working registers
    logic signed [15:0]    w_reg;
    logic                  zero_cmd_reg;
    logic signed [XW-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic signed [XW-1:0]  cx_reg, cy_reg, t_reg, mag_reg;
    logic signed [26:0]    tr_reg;
    logic                  zero_vec_reg;
    logic signed [15:0]    angraw_reg, ang_reg;
    logic signed [15:0]    last_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] flip_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [DIV_BITS-1:0]   q_reg;
    logic                  ovf_reg;

    // Output register
    logic                  out_valid_reg;
    logic [1:0]            idx_reg;
    logic signed [15:0]    steer_reg, rpm_reg;
    logic                  flip_out_reg, sat_reg, last_out_reg;

    // Shared multiplier
    logic signed [XW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [PW-1:0]  prod, prod_sh;
    logic [11:0]           gear60;

    assign gear60 = {gear_reg, 6'b0} - {4'b0, gear_reg, 2'b0};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_GX, OP_VMAG:
            begin
                mul_a = x_reg;
                mul_b = INV_GAIN;
            end
            OP_GY:
            begin
                mul_a = y_reg;
                mul_b = INV_GAIN;
            end
            OP_T1:
            begin
                mul_a = XW'(w_reg);
                mul_b = MW'($signed({1'b0, radius_reg}));
            end
            OP_T2:
            begin
                mul_a = XW'(tr_reg);
                mul_b = YAW_TERM_C;
            end
            OP_RMUL:
            begin
                mul_a = mag_reg;
                mul_b = MW'($signed({1'b0, gear60}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = PW'(mul_a) * PW'(mul_b);
    assign prod_sh = prod >>> 16;

    // CORDIC micro-rotation, shared by rotation and vectoring
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] atan_z;
    logic                 dir_pos;

    assign dx      = y_reg >>> cmd.iter;
    assign dy      = x_reg >>> cmd.iter;
    assign atan_z  = ZW'($signed({1'b0, atan_lut(cmd.iter)}));
    assign dir_pos = (cmd.op == OP_ROT) ? !z_reg[ZW-1] : y_reg[XW-1];

    // Wheel vector: module offsets at 45 degrees
    logic signed [XW-1:0] ax, ay;
    logic                 sx_neg, sy_neg;

    assign sx_neg = (cmd.wheel == 2'd0) || (cmd.wheel == 2'd1);
    assign sy_neg = (cmd.wheel == 2'd0) || (cmd.wheel == 2'd3);
    assign ax     = sx_neg ? (cx_reg - t_reg) : (cx_reg + t_reg);
    assign ay     = sy_neg ? (cy_reg - t_reg) : (cy_reg + t_reg);

    // x/y/z next value
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                x_next = XW'($signed({vel_x, 8'b0}));
                y_next = XW'($signed({vel_y, 8'b0}));
                z_next = -(ZW'(yaw_angle) <<< 10);
            end
            OP_PRE:
            begin
                if (z_reg > DEG90_Z)
                begin
                    x_next = -y_reg;
                    y_next = x_reg;
                    z_next = z_reg - DEG90_Z;
                end
                else if (z_reg < -DEG90_Z)
                begin
                    x_next = y_reg;
                    y_next = -x_reg;
                    z_next = z_reg + DEG90_Z;
                end
            end
            OP_ROT, OP_VEC:
            begin
                if (dir_pos)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z;
                end
            end
            OP_VLOAD:
            begin
                if (ax[XW-1] && !ay[XW-1])
                begin
                    x_next = ay;
                    y_next = -ax;
                    z_next = DEG90_Z;
                end
                else if (ax[XW-1])
                begin
                    x_next = -ay;
                    y_next = ax;
                    z_next = -DEG90_Z;
                end
                else
                begin
                    x_next = ax;
                    y_next = ay;
                    z_next = '0;
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Steering angle update with 180 degree flip
    logic signed [ZW-1:0] zr;
    logic signed [16:0]   diff, fv, fw;
    logic signed [15:0]   last_cur;

    assign zr       = (z_reg + ZW'(512)) >>> 10;
    assign last_cur = last_reg[cmd.wheel];
    assign diff     = 17'(angraw_reg) - 17'(last_cur);

    always_comb
    begin
        fv = (diff > DEG90) ? (17'(angraw_reg) - DEG180) : (17'(angraw_reg) + DEG180);
        if (fv >= DEG360)
        begin
            fw = fv - DEG360;
        end
        else if (fv <= -DEG360)
        begin
            fw = fv + DEG360;
        end
        else
        begin
            fw = fv;
        end
    end

    // Divider
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] den_sh;
    logic [ITER_W-1:0] sh;

    assign den    = {(perim_reg == 11'd0) ? 11'd1 : perim_reg, 8'b0};
    assign sh     = ITER_W'(DIV_BITS - 1) - cmd.iter;
    assign den_sh = NUM_W'(den) << sh;

    // Final rpm with sign and clamp
    logic               rpm_neg;
    logic signed [15:0] rpm_val;
    logic               rpm_sat;

    assign rpm_neg = !dir_reg[cmd.wheel] ^ flip_reg[cmd.wheel];

    always_comb
    begin
        if (!rpm_neg)
        begin
            rpm_sat = ovf_reg || (q_reg > 17'd32767);
            rpm_val = rpm_sat ? 16'sh7FFF : $signed(q_reg[15:0]);
        end
        else
        begin
            rpm_sat = ovf_reg || (q_reg > 17'd32768);
            rpm_val = rpm_sat ? 16'sh8000 : -$signed(q_reg[15:0]);
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.pre_more = (z_reg > DEG90_Z) || (z_reg < -DEG90_Z);

    // Config registers and angle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 10'd300;
            perim_reg  <= 11'd478;
            dir_reg    <= 4'hF;
            gear_reg   <= 6'd19;
            flip_reg   <= '0;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RADIUS:    radius_reg <= cfg_data[9:0];
                    REG_PERIMETER: perim_reg  <= cfg_data;
                    REG_DIR_MASK:  dir_reg    <= cfg_data[3:0];
                    REG_GEAR:      gear_reg   <= cfg_data[5:0];
                endcase
            end
            if (cmd.op == OP_ANG && !zero_cmd_reg)
            begin
                if (diff > DEG90 || diff < -DEG90)
                begin
                    last_reg[cmd.wheel] <= fw[15:0];
                    flip_reg[cmd.wheel] <= 1'b1;
                end
                else
                begin
                    last_reg[cmd.wheel] <= angraw_reg;
                    flip_reg[cmd.wheel] <= 1'b0;
                end
            end
        end
    end

    // Working registers (no reset needed)
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        unique case (cmd.op)
            OP_LOAD:
            begin
                w_reg        <= rot_rate;
                zero_cmd_reg <= (vel_x == 16'sd0) && (vel_y == 16'sd0) && (rot_rate == 16'sd0);
            end
            OP_GX:    cx_reg <= prod_sh[XW-1:0];
            OP_GY:    cy_reg <= prod_sh[XW-1:0];
            OP_T1:    tr_reg <= prod[26:0];
            OP_T2:    t_reg  <= prod_sh[XW-1:0];
            OP_VLOAD: zero_vec_reg <= (ax == '0) && (ay == '0);
            OP_VMAG:
            begin
                if (zero_vec_reg || prod_sh[PW-1])
                begin
                    mag_reg <= '0;
                end
                else
                begin
                    mag_reg <= prod_sh[XW-1:0];
                end
                angraw_reg <= zero_vec_reg ? 16'sd0 : zr[15:0];
            end
            OP_ANG:
            begin
                if (zero_cmd_reg)
                begin
                    ang_reg <= last_cur;
                end
                else if (diff > DEG90 || diff < -DEG90)
                begin
                    ang_reg <= fw[15:0];
                end
                else
                begin
                    ang_reg <= angraw_reg;
                end
            end
            OP_RMUL:  rem_reg <= prod[NUM_W-1:0];
            OP_RADD:  rem_reg <= rem_reg + NUM_W'({perim_reg == 11'd0 ? 11'd1 : perim_reg, 7'b0});
            OP_DCHK:
            begin
                ovf_reg <= (rem_reg >> DIV_BITS) >= NUM_W'(den);
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                if (rem_reg >= den_sh)
                begin
                    rem_reg <= rem_reg - den_sh;
                    q_reg   <= {q_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    q_reg   <= {q_reg[DIV_BITS-2:0], 1'b0};
                end
            end
            default:
            begin
                ovf_reg <= ovf_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            idx_reg      <= cmd.wheel;
            steer_reg    <= ang_reg;
            rpm_reg      <= rpm_val;
            flip_out_reg <= flip_reg[cmd.wheel];
            sat_reg      <= rpm_sat;
            last_out_reg <= (cmd.wheel == 2'd3);
        end
    end

    assign out_valid   = out_valid_reg;
    assign wheel_index = idx_reg;
    assign steer_angle = steer_reg;
    assign motor_rpm   = rpm_reg;
    assign flipped     = flip_out_reg;
    assign saturated   = sat_reg;
    assign last        = last_out_reg;

    // Checks
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (rpm_reg == 16'sh7FFF || rpm_reg == 16'sh8000))
        else $error("saturated result not at a rail");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_out_reg) |-> (idx_reg == 2'd3))
        else $error("last set on a wheel other than the fourth");

endmodule

@@ rtl/sdik_ctrl.sv @@
// Sequencer for the swerve kinematics datapath: steps one request through
// rotation, yaw term, and four wheels of vectoring, rpm divide and output.
// Depends on sdik_pkg.
module sdik_ctrl #(
    parameter int CORDIC_ITERS = sdik_pkg::CORDIC_ITERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sdik_pkg::dp_status_t status,
    output sdik_pkg::dp_cmd_t    cmd
);
    import sdik_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_ROT,
        S_GX,
        S_GY,
        S_T1,
        S_T2,
        S_VLOAD,
        S_VEC,
        S_VMAG,
        S_ANG,
        S_RMUL,
        S_RADD,
        S_DCHK,
        S_DIV,
        S_OUT
    } state_t;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_BITS - 1);

    state_t            state_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [1:0]        wheel_reg;

    // Command decode
    always_comb
    begin
        cmd.wheel    = wheel_reg;
        cmd.iter     = iter_reg;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_PRE:   cmd.op = OP_PRE;
            S_ROT:   cmd.op = OP_ROT;
            S_GX:    cmd.op = OP_GX;
            S_GY:    cmd.op = OP_GY;
            S_T1:    cmd.op = OP_T1;
            S_T2:    cmd.op = OP_T2;
            S_VLOAD: cmd.op = OP_VLOAD;
            S_VEC:   cmd.op = OP_VEC;
            S_VMAG:  cmd.op = OP_VMAG;
            S_ANG:   cmd.op = OP_ANG;
            S_RMUL:  cmd.op = OP_RMUL;
            S_RADD:  cmd.op = OP_RADD;
            S_DCHK:  cmd.op = OP_DCHK;
            S_DIV:   cmd.op = OP_DIV;
            S_OUT:
            begin
                cmd.op       = OP_NONE;
                cmd.out_load = status.out_free;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            wheel_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_PRE;
                    end
                end
                S_PRE:
                begin
                    // one 90 degree step per cycle until the angle is in range
                    iter_reg <= '0;
                    if (!status.pre_more)
                    begin
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST)
                    begin
                        state_reg <= S_GX;
                    end
                end
                S_GX: state_reg <= S_GY;
                S_GY: state_reg <= S_T1;
                S_T1: state_reg <= S_T2;
                S_T2:
                begin
                    wheel_reg <= '0;
                    state_reg <= S_VLOAD;
                end
                S_VLOAD:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST)
                    begin
                        state_reg <= S_VMAG;
                    end
                end
                S_VMAG: state_reg <= S_ANG;
                S_ANG:  state_reg <= S_RMUL;
                S_RMUL: state_reg <= S_RADD;
                S_RADD: state_reg <= S_DCHK;
                S_DCHK:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == DIV_LAST)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (status.out_free)
                    begin
                        if (wheel_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            wheel_reg <= wheel_reg + 1'b1;
                            state_reg <= S_VLOAD;
                        end
                    end
                end
            endcase
        end
    end

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_PRE))
        else $error("accepted request did not start the sequence");

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == S_OUT))
        else $error("result load outside output state");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && status.out_free && wheel_reg == 2'd3) |=> (state_reg == S_IDLE))
        else $error("sequence did not end after the fourth wheel");

endmodule

@@ rtl/swerve_drive_inverse_kinematics.sv @@
// Four-wheel swerve inverse kinematics: top level joining sequencer and datapath.
// Depends on sdik_pkg, sdik_ctrl and sdik_dp.
//
// One request (vel_x, vel_y in mm/s, rot_rate in deg/s, yaw_angle in 1/64 deg)
// yields four results, wheels 0..3, the last with "last" set. A yaw beyond 90
// degrees takes one 90 degree prerotation step before the CORDIC rotation, a
// yaw beyond 180 degrees takes two. One shared CORDIC unit runs a rotation
// pass and four vectoring passes one step a cycle, and a 17-step restoring
// divider forms each wheel's rpm. in_stall stays high until the fourth result
// is loaded into the output register, and the next request can be accepted
// in the cycle after; the output register lets the next request be taken
// while that result still waits. Configuration writes take effect on the
// next request and must be made while the block is idle.
module swerve_drive_inverse_kinematics #(
    parameter int CORDIC_ITERS = sdik_pkg::CORDIC_ITERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] rot_rate,
    input  logic signed [14:0] yaw_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         wheel_index,
    output logic signed [15:0] steer_angle,
    output logic signed [15:0] motor_rpm,
    output logic               flipped,
    output logic               saturated,
    output logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data
);
    import sdik_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sdik_ctrl #(
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sdik_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .rot_rate    (rot_rate),
        .yaw_angle   (yaw_angle),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .wheel_index (wheel_index),
        .steer_angle (steer_angle),
        .motor_rpm   (motor_rpm),
        .flipped     (flipped),
        .saturated   (saturated),
        .last        (last)
    );

endmodule

@@ test/tb.sv @@
// Testbench for swerve_drive_inverse_kinematics: random and directed velocity requests
// checked per wheel against a built-in fixed-point predictor.
// Depends on sdik_pkg and the swerve_drive_inverse_kinematics RTL.
module tb;
    import sdik_pkg::*;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] w;
        logic signed [14:0] yaw;
    } cmd_t;

    typedef struct {
        logic [1:0]         wheel;
        logic signed [15:0] angle;
        logic signed [15:0] rpm;
        logic               flip;
        logic               sat;
        logic               lst;
    } wheel_res_t;

    localparam longint ATAN_Z [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int  N_ITERS   = CORDIC_ITERS_DEF;
    localparam int  WD_LIMIT  = 20000;
    localparam int  HOLD_LEN  = 1500;
    localparam int  DRAIN     = 250;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] vel_x = '0;
    logic signed [15:0] vel_y = '0;
    logic signed [15:0] rot_rate = '0;
    logic signed [14:0] yaw_angle = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         wheel_index;
    logic signed [15:0] steer_angle;
    logic signed [15:0] motor_rpm;
    logic               flipped;
    logic               saturated;
    logic               last;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [10:0]        cfg_data = '0;

    swerve_drive_inverse_kinematics u_top (.*);

    always #5 clk = ~clk;

    // Predictor state and configuration copy
    logic [9:0]         radius_mm;
    logic [10:0]        perim_mm;
    logic [3:0]         dir_mask;
    logic [5:0]         gear;
    int                 target_ang [4];
    logic               flip_mark [4];

    cmd_t               pending [$];
    wheel_res_t         wheel_expect [$];
    int                 n_err = 0;
    bit                 idle_on = 1'b1;
    int                 hold_ask = 0;
    int                 hold_seen = 0;
    int                 hold_cnt = 0;
    int                 in_gap = 0;
    int                 out_gap = 0;
    int                 quiet_cycles = 0;

    // Rotate counterclockwise by z (2^-16 deg) with gain removal
    function automatic void rot_cordic(inout longint x, inout longint y, input longint z);
        longint t, dx, dy;
        while (z > 5898240) begin t = x; x = -y; y = t; z -= 5898240; end
        while (z < -5898240) begin t = x; x = y; y = -t; z += 5898240; end
        for (int i = 0; i < N_ITERS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= ATAN_Z[i]; end
            else begin x += dx; y -= dy; z += ATAN_Z[i]; end
        end
        x = (x * 39797) >>> 16;
        y = (y * 39797) >>> 16;
    endfunction

    // atan2 in 1/64 deg and magnitude
    function automatic void vec_cordic(input longint x, input longint y,
                                       output int ang, output longint mag);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            mag = 0;
            return;
        end
        if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = 5898240; end
            else begin t = x; x = -y; y = t; z = -5898240; end
        end
        for (int i = 0; i < N_ITERS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin x += dx; y -= dy; z += ATAN_Z[i]; end
            else begin x -= dx; y += dy; z -= ATAN_Z[i]; end
        end
        ang = int'((z + 512) >>> 10);
        mag = (x * 39797) >>> 16;
        if (mag < 0) mag = 0;
    endfunction

    // Compute the four wheel results of one request and queue them
    function automatic void predict_wheels(input cmd_t c);
        longint cx, cy, t, ax, ay, mag, val;
        longint unsigned den, r;
        int ang, d, sx, sy;
        bit zero_cmd, neg, sat;
        wheel_res_t res;
        zero_cmd = (c.vx == 0 && c.vy == 0 && c.w == 0);
        cx = longint'(c.vx) * 256;
        cy = longint'(c.vy) * 256;
        den = longint'((perim_mm != 0) ? perim_mm : 11'd1) * 256;
        rot_cordic(cx, cy, -longint'(c.yaw) * 1024);
        t = (longint'(c.w) * longint'(radius_mm) * 207053) >>> 16;
        for (int i = 0; i < 4; i++) begin
            sx = (i < 2) ? -1 : 1;
            sy = (i == 0 || i == 3) ? -1 : 1;
            ax = cx + sx * t;
            ay = cy + sy * t;
            vec_cordic(ax, ay, ang, mag);
            if (zero_cmd) begin
                ang = target_ang[i];
            end
            else begin
                d = ang - target_ang[i];
                if (d > 5760) begin ang = (ang - 11520) % 23040; flip_mark[i] = 1'b1; end
                else if (d < -5760) begin ang = (ang + 11520) % 23040; flip_mark[i] = 1'b1; end
                else flip_mark[i] = 1'b0;
            end
            target_ang[i] = ang;
            r = (longint'(mag) * 60 * gear + den / 2) / den;
            neg = (dir_mask[i] == 1'b0) != flip_mark[i];
            val = neg ? -longint'(r) : longint'(r);
            sat = 1'b0;
            if (val > 32767) begin val = 32767; sat = 1'b1; end
            if (val < -32768) begin val = -32768; sat = 1'b1; end
            res.wheel = i[1:0];
            res.angle = ang[15:0];
            res.rpm   = val[15:0];
            res.flip  = flip_mark[i];
            res.sat   = sat;
            res.lst   = (i == 3);
            wheel_expect.push_back(res);
        end
    endfunction

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 14) : 0;
    endfunction

    // Mostly moderate commands, some full-range noise, some zero commands
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            c.vx  = 16'(int'($urandom_range(0, 8000)) - 4000);
            c.vy  = 16'(int'($urandom_range(0, 8000)) - 4000);
            c.w   = 16'(int'($urandom_range(0, 1440)) - 720);
            c.yaw = 15'(int'($urandom_range(0, 23040)) - 11520);
        end
        else if (k < 9) begin
            c.vx  = 16'($urandom);
            c.vy  = 16'($urandom);
            c.w   = 16'($urandom);
            c.yaw = 15'($urandom);
        end
        else begin
            c.vx = '0;
            c.vy = '0;
            c.w  = '0;
            c.yaw = 15'($urandom);
        end
        return c;
    endfunction

    function automatic cmd_t mk(input int x, input int y, input int w, input int yw);
        cmd_t c;
        c.vx = 16'(x);
        c.vy = 16'(y);
        c.w = 16'(w);
        c.yaw = 15'(yw);
        return c;
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n) begin
        cmd_t c;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                predict_wheels(mk(vel_x, vel_y, rot_rate, yaw_angle));
            if (!in_valid || !in_stall) begin
                if (in_gap != 0) begin
                    in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (pending.size() > 0) begin
                    c = pending.pop_front();
                    vel_x <= c.vx;
                    vel_y <= c.vy;
                    rot_rate <= c.w;
                    yaw_angle <= c.yaw;
                    in_valid <= 1'b1;
                    in_gap <= draw_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output stall
    always @(posedge clk or negedge rst_n) begin
        wheel_res_t e;
        int g;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_gap <= 0;
            hold_cnt <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (wheel_expect.size() == 0) begin
                    $error("unexpected result for wheel %0d", wheel_index);
                    n_err++;
                end
                else begin
                    e = wheel_expect.pop_front();
                    if (wheel_index !== e.wheel) begin
                        $error("wheel_index exp %0d got %0d", e.wheel, wheel_index);
                        n_err++;
                    end
                    if (steer_angle !== e.angle) begin
                        $error("steer_angle exp %0d got %0d", e.angle, steer_angle);
                        n_err++;
                    end
                    if (motor_rpm !== e.rpm) begin
                        $error("motor_rpm exp %0d got %0d", e.rpm, motor_rpm);
                        n_err++;
                    end
                    if (flipped !== e.flip) begin
                        $error("flipped exp %0d got %0d", e.flip, flipped);
                        n_err++;
                    end
                    if (saturated !== e.sat) begin
                        $error("saturated exp %0d got %0d", e.sat, saturated);
                        n_err++;
                    end
                    if (last !== e.lst) begin
                        $error("last exp %0d got %0d", e.lst, last);
                        n_err++;
                    end
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else if (hold_ask != hold_seen) begin
                hold_seen <= hold_ask;
                hold_cnt <= HOLD_LEN;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall) begin
                g = draw_gap();
                out_gap <= g;
                out_stall <= (g != 0);
            end
            else if (out_gap > 1) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_gap <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_cfg(input int rad, input int per, input int msk, input int gr);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_RADIUS; cfg_data <= 11'(rad);
        @(posedge clk);
        cfg_index <= REG_PERIMETER; cfg_data <= 11'(per);
        @(posedge clk);
        cfg_index <= REG_DIR_MASK; cfg_data <= 11'(msk);
        @(posedge clk);
        cfg_index <= REG_GEAR; cfg_data <= 11'(gr);
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_mm = 10'(rad);
        perim_mm = 11'(per);
        dir_mask = 4'(msk);
        gear = 6'(gr);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || in_valid || wheel_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            pending.push_back(rand_cmd());
        wait_idle();
    endtask

    initial begin
        radius_mm = 300;
        perim_mm = 478;
        dir_mask = 15;
        gear = 19;
        for (int i = 0; i < 4; i++) begin
            target_ang[i] = 0;
            flip_mark[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset values, extremes, flips, zero command
        write_cfg(300, 478, 15, 19);
        pending.push_back(mk(0, 0, 0, 0));
        pending.push_back(mk(1000, 0, 0, 0));
        pending.push_back(mk(-1000, 0, 0, 0));
        pending.push_back(mk(0, 0, 0, 500));
        pending.push_back(mk(-1000, 10, 0, 0));
        pending.push_back(mk(32767, 32767, 32767, 11520));
        pending.push_back(mk(-32768, -32768, -32768, -11520));
        pending.push_back(mk(32767, -32768, 0, -16384));
        pending.push_back(mk(-32768, 32767, 0, 16383));
        pending.push_back(mk(0, 1500, 0, 5760));
        pending.push_back(mk(0, -1500, 0, -5760));
        pending.push_back(mk(0, 0, 360, 0));
        pending.push_back(mk(0, 0, -360, 0));
        pending.push_back(mk(0, 0, 0, -11520));
        pending.push_back(mk(500, 500, 90, 2880));
        pending.push_back(mk(-500, -500, -90, -2880));
        wait_idle();

        // Zero radius: pure rotation gives zero wheel vectors
        write_cfg(0, 1, 0, 63);
        pending.push_back(mk(0, 0, 1000, 0));
        pending.push_back(mk(0, 0, -32768, 100));
        pending.push_back(mk(2000, -2000, 5, 0));
        wait_idle();

        // Zero perimeter and zero gear
        write_cfg(1023, 0, 10, 0);
        pending.push_back(mk(3000, 3000, 300, 1000));
        wait_idle();

        // Random phases over several settings, one with a long receiver hold
        idle_on = 1'b1;
        hold_ask++;
        run_random(60);
        write_cfg(1023, 2047, 5, 1);
        idle_on = 1'b0;
        run_random(50);
        write_cfg(0, 1, 0, 63);
        idle_on = 1'b1;
        run_random(50);
        write_cfg($urandom_range(0, 1023), $urandom_range(1, 2047),
                  $urandom_range(0, 15), $urandom_range(1, 63));
        run_random(50);
        write_cfg(300, 478, 15, 19);
        run_random(50);

        if (n_err == 0 && wheel_expect.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
